// ===== rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  localparam int PRICE_BITS     = 32;
  localparam int SYMBOL_BITS    = 16;
  localparam int RSI_BITS       = 15;
  localparam int PERIOD_BITS    = 7;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MAX_PERIOD_DEF = 64;
  localparam int DIV_CNT_BITS   = $clog2(RSI_BITS);

  // 25600 = 2^14 + 2^13 + 2^10
  localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;
  localparam int RSI_SH0 = 14;
  localparam int RSI_SH1 = 13;
  localparam int RSI_SH2 = 10;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RST     = 7'd14;
  localparam logic [RSI_BITS-1:0]    OVERBOUGHT_RST = 15'd17920;
  localparam logic [RSI_BITS-1:0]    OVERSOLD_RST   = 15'd7680;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PERIOD     = 2'd0,
    CFG_OVERBOUGHT = 2'd1,
    CFG_OVERSOLD   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_NEXT,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0]  price;
    logic [SYMBOL_BITS-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [RSI_BITS-1:0]    rsi;
    logic                   rsi_valid;
    logic [1:0]             signal;
    logic [SYMBOL_BITS-1:0] symbol_out;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic rd_old;
    logic rd_next;
    logic latch_a;
    logic update;
    logic prep;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
    logic fills;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rsi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsi_pkg::dp_sts_t sts,
  output rsi_pkg::dp_cmd_t cmd
);
  import rsi_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_CNT_BITS-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = sts.need_read ? ST_RD_OLD : ST_UPDATE;
        end
      end
      ST_RD_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        cmd.rd_next = 1'b1;
        cmd.latch_a = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.fills ? ST_PREP : ST_FINISH;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = DIV_CNT_BITS'(RSI_BITS - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rsi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsi_dp #(
  parameter int MAX_PERIOD = rsi_pkg::MAX_PERIOD_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rsi_pkg::in_item_t                  in_data,
  input  logic                               cfg_we,
  input  logic [rsi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  rsi_pkg::dp_cmd_t                   cmd,
  output rsi_pkg::dp_sts_t                   sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rsi_pkg::out_item_t                 out_data
);
  import rsi_pkg::*;

  localparam int IDX_W = $clog2(MAX_PERIOD);
  localparam int CNT_W = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W = PRICE_BITS + IDX_W;
  localparam int NUM_W = SUM_W + RSI_BITS;

  // configuration
  logic [PERIOD_BITS-1:0] period;
  logic [RSI_BITS-1:0]    overbought;
  logic [RSI_BITS-1:0]    oversold;

  // window state
  logic [CNT_W-1:0]      fill;
  logic [IDX_W-1:0]      oldest;
  logic [SUM_W-1:0]      gain;
  logic [SUM_W-1:0]      loss;
  logic                  holding;
  logic [PRICE_BITS-1:0] last_price;

  // per-request registers
  logic [PRICE_BITS-1:0]  price_r;
  logic [SYMBOL_BITS-1:0] symbol_r;
  logic                   sub_r;
  logic [PRICE_BITS-1:0]  old_a;

  // divider
  logic [SUM_W-1:0]    divisor;
  logic [SUM_W-1:0]    rem;
  logic [RSI_BITS-1:0] nlow;
  logic [RSI_BITS-1:0] quo;

  logic [CNT_W-1:0]      eff_p;
  logic                  full;
  logic                  p_one;
  logic [IDX_W-1:0]      oldest_inc;
  logic [IDX_W-1:0]      waddr;
  logic [IDX_W-1:0]      raddr;
  logic [PRICE_BITS-1:0] rdata;
  logic [PRICE_BITS-1:0] d_new;
  logic [PRICE_BITS-1:0] d_old;
  logic                  new_up;
  logic                  old_up;
  logic                  add_en;
  logic [SUM_W-1:0]      gain_next;
  logic [SUM_W-1:0]      loss_next;
  logic [NUM_W-1:0]      num;
  logic [SUM_W:0]        trial;
  logic                  ge;
  logic [RSI_BITS-1:0]   rsi_val;
  logic [1:0]            sig;
  logic                  holding_next;

  always_comb begin
    if (period == '0) begin
      eff_p = CNT_W'(1);
    end else if (32'(period) > 32'(MAX_PERIOD)) begin
      eff_p = CNT_W'(MAX_PERIOD);
    end else begin
      eff_p = CNT_W'(period);
    end
  end

  assign full       = (fill == eff_p);
  assign p_one      = (eff_p == CNT_W'(1));
  assign oldest_inc = ((CNT_W'(oldest) + CNT_W'(1)) == eff_p) ? '0 : oldest + 1'b1;
  assign waddr      = full ? oldest : fill[IDX_W-1:0];
  assign raddr      = cmd.rd_next ? oldest_inc : oldest;

  assign sts.need_read = full && !p_one;
  assign sts.fills     = full || ((fill + 1'b1) == eff_p);
  assign sts.out_free  = !out_valid || out_ready;

  rsi_ram #(
    .WIDTH(PRICE_BITS),
    .DEPTH(MAX_PERIOD)
  ) u_window (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(waddr),
    .wdata(price_r),
    .re   (cmd.rd_old | cmd.rd_next),
    .raddr(raddr),
    .rdata(rdata)
  );

  // running sums: drop the oldest difference, add the newest
  assign new_up = price_r > last_price;
  assign d_new  = new_up ? price_r - last_price : last_price - price_r;
  assign old_up = rdata > old_a;
  assign d_old  = old_up ? rdata - old_a : old_a - rdata;
  assign add_en = (fill != '0) && !p_one;

  always_comb begin
    gain_next = gain;
    loss_next = loss;
    if (sub_r) begin
      if (old_up) begin
        gain_next = gain_next - SUM_W'(d_old);
      end else begin
        loss_next = loss_next - SUM_W'(d_old);
      end
    end
    if (add_en) begin
      if (new_up) begin
        gain_next = gain_next + SUM_W'(d_new);
      end else begin
        loss_next = loss_next + SUM_W'(d_new);
      end
    end
  end

  // 25600 * gain as shift-and-add
  assign num = (NUM_W'(gain) << RSI_SH0) + (NUM_W'(gain) << RSI_SH1)
             + (NUM_W'(gain) << RSI_SH2);

  assign trial = {rem, nlow[RSI_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    rsi_val      = (loss == '0) ? RSI_FULL : quo;
    sig          = SIG_NONE;
    holding_next = holding;
    if (full) begin
      if ((rsi_val > overbought) && holding) begin
        sig          = SIG_SELL;
        holding_next = 1'b0;
      end else if ((rsi_val < oversold) && !holding) begin
        sig          = SIG_BUY;
        holding_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RST;
      overbought <= OVERBOUGHT_RST;
      oversold   <= OVERSOLD_RST;
      fill       <= '0;
      oldest     <= '0;
      gain       <= '0;
      loss       <= '0;
      holding    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.update) begin
        gain <= gain_next;
        loss <= loss_next;
        if (full) begin
          oldest <= oldest_inc;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.finish) begin
        holding   <= holding_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PERIOD: begin
            period <= cfg_data[PERIOD_BITS-1:0];
            fill   <= '0;
            oldest <= '0;
            gain   <= '0;
            loss   <= '0;
          end
          CFG_OVERBOUGHT: overbought <= cfg_data[RSI_BITS-1:0];
          CFG_OVERSOLD:   oversold   <= cfg_data[RSI_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      price_r  <= in_data.price;
      symbol_r <= in_data.symbol;
      sub_r    <= sts.need_read;
    end
    if (cmd.latch_a) begin
      old_a <= rdata;
    end
    if (cmd.update) begin
      last_price <= price_r;
    end
    if (cmd.prep) begin
      divisor <= gain + loss;
      rem     <= num[NUM_W-1:RSI_BITS];
      nlow    <= num[RSI_BITS-1:0];
      quo     <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
      nlow <= {nlow[RSI_BITS-2:0], 1'b0};
      quo  <= {quo[RSI_BITS-2:0], ge};
    end
    if (cmd.finish) begin
      out_data.rsi        <= full ? rsi_val : '0;
      out_data.rsi_valid  <= full;
      out_data.signal     <= sig;
      out_data.symbol_out <= symbol_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsi_threshold_signal_core.sv =====
// per request: two window reads when full and the period is above 1, then sum update,
// numerator setup and 15-step divide if the window is or becomes full, output load
// one request at a time, taken when idle; the divider makes one quotient bit per cycle
// a finished result waits in the output register while the next request is taken
// reset: synchronous rst empties the window, clears the position flag and sums,
// and loads period 14, overbought 17920, oversold 7680
`timescale 1ns / 1ps
`default_nettype none

module rsi_threshold_signal_core #(
  parameter int MAX_PERIOD = rsi_pkg::MAX_PERIOD_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rsi_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rsi_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [rsi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rsi_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rsi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rsi_dp #(
    .MAX_PERIOD(MAX_PERIOD)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/rsi_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsi_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rsi_pkg::out_item_t out_data
);
  import rsi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_unfilled_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.rsi_valid |-> out_data.rsi == '0 && out_data.signal == SIG_NONE)
    else $error("rsi or signal set before window full");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rsi <= RSI_FULL
      && (out_data.signal == SIG_NONE || out_data.signal == SIG_BUY
          || out_data.signal == SIG_SELL))
    else $error("rsi or signal out of range");

endmodule

bind rsi_threshold_signal_core rsi_chk u_rsi_chk (.*);

`default_nettype wire
